// File: hw/rtl/uor_pkg.sv
// Shared types and constants for the ultrasonic occupancy ranger.
package uor_pkg;

   localparam int CNT_W      = 24;
   localparam int TRIG_W     = 8;
   localparam int TMO_W      = 16;
   localparam int DIST_W     = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Echo width never exceeds the 16-bit timeout, one spare bit for margin.
   localparam int WIDTH_W    = 17;
   localparam int SCALE_W    = 9;
   localparam int PROD_W     = WIDTH_W + SCALE_W;
   localparam int SCALE_SHIFT = 10;
   localparam logic [SCALE_W-1:0] SCALE_NUM = 9'd281;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Survey phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_TRIG = 2'd1;
   localparam logic [1:0] PH_RISE = 2'd2;
   localparam logic [1:0] PH_HIGH = 2'd3;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DISTANCE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OCC_DISTANCE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_MODE   = 3'd5;

   typedef struct packed {
      logic [CNT_W-1:0]  update_period_us;
      logic [TRIG_W-1:0] trigger_width_us;
      logic [TMO_W-1:0]  echo_timeout_us;
      logic [DIST_W-1:0] max_distance_q4;
      logic [DIST_W-1:0] occupied_distance_q4;
      logic              single_channel_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      update_period_us:     24'd500000,
      trigger_width_us:     8'd10,
      echo_timeout_us:      16'd30000,
      max_distance_q4:      15'd6400,
      occupied_distance_q4: 15'd320,
      single_channel_mode:  1'b0
   };

   typedef struct packed {
      logic [1:0]       phase;
      logic             active_channel;
      logic [CNT_W-1:0] tick_counter;
      logic [1:0]       occupancy_flags;
   } state_type;

   typedef struct packed {
      logic              trigger_a;
      logic              trigger_b;
      logic              result_valid;
      logic              result_channel;
      logic [DIST_W-1:0] distance_q4;
      logic              occupied_a;
      logic              occupied_b;
   } result_type;

endpackage

// File: hw/rtl/uor_step.sv
// One-tick update of the ranging sequencer: next state and result beat.
module uor_step (
   input  uor_pkg::cfg_type    cfg,
   input  uor_pkg::state_type  cur,
   input  logic                echo_level_a,
   input  logic                echo_level_b,
   output uor_pkg::state_type  nxt,
   output uor_pkg::result_type res
);
   import uor_pkg::*;

   logic                echo;
   logic [CNT_W-1:0]    cnt_inc;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-SCALE_SHIFT-1:0] scaled;
   logic [DIST_W-1:0]   width_dist;
   logic                fin;
   logic [DIST_W-1:0]   fin_dist;
   logic                occ;
   logic [1:0]          flags;

   assign echo    = cur.active_channel ? echo_level_b : echo_level_a;
   assign cnt_inc = cur.tick_counter + CNT_W'(1);

   // distance = (w * 281) >> 10, saturated to max distance
   assign prod   = PROD_W'(cur.tick_counter[WIDTH_W-1:0]) * PROD_W'(SCALE_NUM);
   assign scaled = prod[PROD_W-1:SCALE_SHIFT];
   assign width_dist = (scaled > (PROD_W-SCALE_SHIFT)'(cfg.max_distance_q4))
                       ? cfg.max_distance_q4 : scaled[DIST_W-1:0];

   always_comb begin
      nxt      = cur;
      fin      = 1'b0;
      fin_dist = '0;
      occ      = 1'b0;
      flags    = cur.occupancy_flags;

      res.trigger_a      = (cur.phase == PH_TRIG) && !cur.active_channel;
      res.trigger_b      = (cur.phase == PH_TRIG) &&  cur.active_channel;
      res.result_valid   = 1'b0;
      res.result_channel = 1'b0;
      res.distance_q4    = '0;

      case (cur.phase)
         PH_TRIG: begin
            nxt.tick_counter = cnt_inc;
            if (cnt_inc >= CNT_W'(cfg.trigger_width_us)) begin
               nxt.tick_counter = '0;
               nxt.phase        = PH_RISE;
            end
         end
         PH_RISE: begin
            if (echo) begin
               nxt.tick_counter = CNT_W'(1);
               nxt.phase        = PH_HIGH;
            end else begin
               nxt.tick_counter = cnt_inc;
               if (cnt_inc > CNT_W'(cfg.echo_timeout_us)) begin
                  fin      = 1'b1;
                  fin_dist = cfg.max_distance_q4;
               end
            end
         end
         PH_HIGH: begin
            if (!echo) begin
               fin      = 1'b1;
               fin_dist = width_dist;
            end else begin
               nxt.tick_counter = cnt_inc;
               if (cnt_inc > CNT_W'(cfg.echo_timeout_us)) begin
                  fin      = 1'b1;
                  fin_dist = cfg.max_distance_q4;
               end
            end
         end
         default: begin
            nxt.phase = PH_IDLE;
            if (cur.tick_counter != CNT_MAX) begin
               nxt.tick_counter = cnt_inc;
            end
            if (nxt.tick_counter > cfg.update_period_us) begin
               nxt.tick_counter   = '0;
               nxt.active_channel = 1'b0;
               nxt.phase          = PH_TRIG;
            end
         end
      endcase

      if (fin) begin
         occ = (fin_dist != '0) && (fin_dist < cfg.occupied_distance_q4);
         flags[cur.active_channel] = occ;
         res.result_valid   = 1'b1;
         res.result_channel = cur.active_channel;
         res.distance_q4    = fin_dist;
         nxt.tick_counter   = '0;
         if (!cur.active_channel && !cfg.single_channel_mode) begin
            nxt.active_channel = 1'b1;
            nxt.phase          = PH_TRIG;
         end else begin
            // single-channel survey keeps spot 1 free
            if (cfg.single_channel_mode) begin
               flags[1] = 1'b0;
            end
            nxt.active_channel = 1'b0;
            nxt.phase          = PH_IDLE;
         end
      end

      nxt.occupancy_flags = flags;
      res.occupied_a      = flags[0];
      res.occupied_b      = flags[1];
   end

endmodule

// File: hw/rtl/ultrasonic_occupancy_ranger_top.sv
// Top level of the two-spot ultrasonic occupancy ranger.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+-----------------------------------
//  req     | in        | req_valid/req_stall | one 1 us tick: both echo levels
//  rsp     | out       | rsp_valid/rsp_stall | triggers, finished measurement,
//          |           |                     | occupancy flags for that tick
//  csr     | in        | csr_valid/csr_ready | register index + write data
//
// Every tick beat gives exactly one rsp beat. A beat lands in the input
// register, then one pass of the step logic (one 17x9 multiply plus compares)
// updates the sequencer and fills the output register; one beat per cycle is
// sustained while rsp_stall is low.
// Synchronous active-high reset clears the sequencer, the pipeline valids and
// loads the register defaults. csr_ready is always high.
// rsp_stall holds the output register; the input register then holds too, and
// req_stall rises only while the input register is full and cannot drain.
module ultrasonic_occupancy_ranger_top (
   input  logic                            clock,
   input  logic                            reset,
   // tick input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_echo_level_a,
   input  logic                            req_echo_level_b,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_trigger_a,
   output logic                            rsp_trigger_b,
   output logic                            rsp_result_valid,
   output logic                            rsp_result_channel,
   output logic [uor_pkg::DIST_W-1:0]      rsp_distance_q4,
   output logic                            rsp_occupied_a,
   output logic                            rsp_occupied_b,
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [uor_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [uor_pkg::CSR_DATA_W-1:0]  csr_data
);
   import uor_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       echo_a_ff, echo_b_ff;
   // sequencer state and registers
   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   // output register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   state_type  step_nxt;
   result_type step_res;
   logic       out_free;
   logic       advance;
   logic       req_take;

   // output register can take a beat when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   uor_step u_step (
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .echo_level_a (echo_a_ff),
      .echo_level_b (echo_b_ff),
      .nxt          (step_nxt),
      .res          (step_res)
   );

   // sequencer moves only when a tick passes into the output register
   assign state_in    = advance ? step_nxt : state_ff;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_UPDATE_PERIOD: cfg_in.update_period_us     = csr_data;
            CSR_TRIGGER_WIDTH: cfg_in.trigger_width_us     = csr_data[TRIG_W-1:0];
            CSR_ECHO_TIMEOUT:  cfg_in.echo_timeout_us      = csr_data[TMO_W-1:0];
            CSR_MAX_DISTANCE:  cfg_in.max_distance_q4      = csr_data[DIST_W-1:0];
            CSR_OCC_DISTANCE:  cfg_in.occupied_distance_q4 = csr_data[DIST_W-1:0];
            CSR_SINGLE_MODE:   cfg_in.single_channel_mode  = csr_data[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, active_channel: 1'b0,
                           tick_counter: '0, occupancy_flags: 2'b00};
         cfg_ff       <= CFG_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         echo_a_ff <= req_echo_level_a;
         echo_b_ff <= req_echo_level_b;
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_trigger_a      = out_ff.trigger_a;
   assign rsp_trigger_b      = out_ff.trigger_b;
   assign rsp_result_valid   = out_ff.result_valid;
   assign rsp_result_channel = out_ff.result_channel;
   assign rsp_distance_q4    = out_ff.distance_q4;
   assign rsp_occupied_a     = out_ff.occupied_a;
   assign rsp_occupied_b     = out_ff.occupied_b;

endmodule
